>>> src/cdq_pkg.sv
// ============================================================================
// cdq_pkg
// Shared opcodes, status codes and the decoded command type of the deque.
// ============================================================================
package cdq_pkg;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Entries in the command queue between front and engine
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic               is_pop;
        logic               at_rear;
        logic signed [31:0] value;
    } cmd_t;

endpackage

>>> src/cdq_front.sv
// ============================================================================
// cdq_front
// Accept requests, decode the opcode and hold them in a two-entry queue.
// ============================================================================
module cdq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  logic signed [31:0]   push_value,
    output logic                 cmd_valid,
    output cdq_pkg::cmd_t        cmd,
    input  logic                 cmd_take
);

    cdq_pkg::cmd_t q_reg [cdq_pkg::CMDQ_DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          wr_en;
    logic          rd_en;
    cdq_pkg::cmd_t dec;

    assign full      = (cnt_reg == 2'(cdq_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    // Classify the request
    always_comb
    begin
        dec.is_pop  = (opcode == cdq_pkg::OP_POP_FRONT) || (opcode == cdq_pkg::OP_POP_REAR);
        dec.at_rear = (opcode == cdq_pkg::OP_PUSH_REAR) || (opcode == cdq_pkg::OP_POP_REAR);
        dec.value   = push_value;
    end

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

>>> src/cdq_engine.sv
// ============================================================================
// cdq_engine
// Execute deque commands against the circular store and register results.
// ============================================================================
module cdq_engine #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cdq_pkg::cmd_t        cmd,
    output logic                 cmd_take,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   pop_value,
    output logic [1:0]           status,
    output logic [4:0]           occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          res_valid_reg, res_valid_next;
    logic signed [31:0] res_value_reg;
    logic [1:0]    res_status_reg;
    logic [4:0]    res_occ_reg;

    logic          out_pop;
    logic          issue;
    logic          is_full;
    logic          is_empty;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic          load_status;
    logic [1:0]    status_new;
    logic [CW-1:0] occ_new;
    logic          direct_done;

    assign empty     = !res_valid_reg;
    assign pop_value = res_value_reg;
    assign status    = res_status_reg;
    assign occupancy = res_occ_reg;

    assign out_pop  = pop && res_valid_reg;
    assign issue    = cmd_valid && !rd_pend_reg && (!res_valid_reg || out_pop);
    assign cmd_take = issue;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - AW'(1);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = head_reg;
        load_status  = 1'b0;
        status_new   = cdq_pkg::ST_DONE;
        occ_new      = count_reg;
        direct_done  = 1'b0;
        rd_pend_next = 1'b0;

        if (issue)
        begin
            load_status = 1'b1;
            if (!cmd.is_pop)
            begin
                direct_done = 1'b1;
                if (is_full)
                begin
                    status_new = cdq_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    occ_new    = count_next;
                    if (cmd.at_rear)
                    begin
                        mem_addr  = tail_reg;
                        tail_next = tail_inc;
                    end
                    else
                    begin
                        mem_addr  = head_dec;
                        head_next = head_dec;
                    end
                end
            end
            else if (is_empty)
            begin
                direct_done = 1'b1;
                status_new  = cdq_pkg::ST_EMPTY;
            end
            else
            begin
                mem_re       = 1'b1;
                rd_pend_next = 1'b1;
                count_next   = count_reg - CW'(1);
                occ_new      = count_next;
                if (cmd.at_rear)
                begin
                    mem_addr  = tail_dec;
                    tail_next = tail_dec;
                end
                else
                begin
                    mem_addr  = head_reg;
                    head_next = head_inc;
                end
            end
        end

        res_valid_next = res_valid_reg;
        if (out_pop)
        begin
            res_valid_next = 1'b0;
        end
        if (direct_done || rd_pend_reg)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd.value;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Result payload: status and occupancy at issue, value when known
    always_ff @(posedge clk)
    begin
        if (load_status)
        begin
            res_status_reg <= status_new;
            res_occ_reg    <= 5'(occ_new);
        end
        if (direct_done)
        begin
            res_value_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            res_value_reg <= rd_data_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !res_valid_reg)
        else $error("read pending while result slot occupied");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> (head_reg == tail_reg))
        else $error("pointers disagree with count");

    a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> (rd_pend_reg || res_valid_reg))
        else $error("taken command produced no result");

endmodule

>>> src/circular_deque.sv
// ============================================================================
// circular_deque
// Double-ended queue of signed 32-bit values in a circular store.
// ============================================================================
// Order: requests wait in the command queue; a push or a refused request
//   then fills the result slot; a successful pop goes via the registered read.
// Throughput: pushes and refused requests run at 1 per cycle while results
//   are popped; no command issues while a pop's store read is pending.
// Reset: rst_n clears pointers, element count, command queue and result slot;
//   store contents are left as they are and are only read after a push.
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Request side
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  logic signed [31:0]   push_value,
    // Result side
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   pop_value,
    output logic [1:0]           status,
    output logic [4:0]           occupancy
);

    // Decoded command passing from the front queue to the engine
    logic          cmd_valid;
    logic          cmd_take;
    cdq_pkg::cmd_t cmd;

    // Front: accept each request, decode it, and hold it in a small queue so
    // that request acceptance waits on the engine only when the queue is full.
    cdq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .push_value (push_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    // Back: advance the head or tail pointer, make at most one store access, and
    // hold the result in a one-entry output slot until it is popped.
    cdq_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .pop_value (pop_value),
        .status    (status),
        .occupancy (occupancy)
    );

endmodule

>>> tb/deque_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// deque_checker
// Watches the request and result channels of the circular deque. Keeps its
// own copy of the store, both pointers and the occupancy, works out the
// result of every accepted request, and compares each popped result field by
// field with the oldest result still owed.
// ============================================================================
module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] push_value,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] pop_value,
    input  logic [1:0]         status,
    input  logic [4:0]         occupancy,
    output int                 mismatches,
    output int                 pending,
    output int                 requests_seen,
    output int                 results_seen,
    output int                 refused_full,
    output int                 refused_empty
);

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } deque_result_t;

    logic [31:0]   slots [DEPTH];
    int unsigned   front_idx;
    int unsigned   back_idx;
    int unsigned   stored;
    deque_result_t owed_results [$];

    // Apply one request to the deque copy and return the result it owes.
    function automatic deque_result_t apply_request(input logic [1:0] op,
                                                    input logic [31:0] val);
        deque_result_t r;
        r = '0;
        r.status = cdq_pkg::ST_DONE;
        if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR)
        begin
            if (stored == DEPTH)
            begin
                r.status = cdq_pkg::ST_FULL;
            end
            else if (op == cdq_pkg::OP_PUSH_FRONT)
            begin
                front_idx = (front_idx + DEPTH - 1) % DEPTH;
                slots[front_idx] = val;
                stored++;
            end
            else
            begin
                slots[back_idx] = val;
                back_idx = (back_idx + 1) % DEPTH;
                stored++;
            end
        end
        else
        begin
            if (stored == 0)
            begin
                r.status = cdq_pkg::ST_EMPTY;
            end
            else if (op == cdq_pkg::OP_POP_FRONT)
            begin
                r.pop_value = slots[front_idx];
                front_idx = (front_idx + 1) % DEPTH;
                stored--;
            end
            else
            begin
                back_idx = (back_idx + DEPTH - 1) % DEPTH;
                r.pop_value = slots[back_idx];
                stored--;
            end
        end
        r.occupancy = 5'(stored);
        return r;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            front_idx     = 0;
            back_idx      = 0;
            stored        = 0;
            mismatches    = 0;
            requests_seen = 0;
            results_seen  = 0;
            refused_full  = 0;
            refused_empty = 0;
            owed_results.delete();
        end
        else
        begin
            // Results first: a request taken at this edge cannot answer yet.
            if (pop && !empty)
            begin
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing owed (value %0d)",
                                              pop_value));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (pop_value !== want.pop_value)
                        report_mismatch($sformatf("pop_value expected %0d, got %0d",
                                                  want.pop_value, pop_value));
                    if (status !== want.status)
                        report_mismatch($sformatf("status expected %0d, got %0d",
                                                  want.status, status));
                    if (occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy expected %0d, got %0d",
                                                  want.occupancy, occupancy));
                end
            end
            if (push && !full)
            begin
                requests_seen++;
                want = apply_request(opcode, push_value);
                if (want.status == cdq_pkg::ST_FULL)
                    refused_full++;
                if (want.status == cdq_pkg::ST_EMPTY)
                    refused_empty++;
                owed_results.push_back(want);
            end
        end
        pending <= owed_results.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Top of the circular deque bench: drives requests and result pops.
// A short directed run covers empty pops, last-element pops, filling to full
// and pushes on a full store; then about 450 random requests in fill, drain
// and mixed runs go through three idling mixes, with one long result hold-off.
// ============================================================================
module testbench;

    localparam int DEPTH        = 16;
    // Quiet cycles (nothing accepted on either side) before giving up
    localparam int QUIET_LIMIT  = 2000;
    // Length of the one long result hold-off
    localparam int HOLD_CYCLES  = 80;
    localparam int ITEMS_PER_MIX = 150;
    // Cycles to watch for stray results after the last one owed
    localparam int DRAIN_CYCLES = 12;

    typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               push       = 1'b0;
    logic [1:0]         opcode     = cdq_pkg::OP_PUSH_FRONT;
    logic signed [31:0] push_value = '0;
    logic               pop        = 1'b0;
    logic               full;
    logic               empty;
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;

    int  send_idle_pct = 18;
    int  recv_idle_pct = 75;
    logic steady_mix   = 1'b0;
    logic hold_done    = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;

    int mismatches;
    int pending;
    int requests_seen;
    int results_seen;
    int refused_full;
    int refused_empty;

    circular_deque #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .push_value(push_value),
        .empty     (empty),
        .pop       (pop),
        .pop_value (pop_value),
        .status    (status),
        .occupancy (occupancy)
    );

    deque_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .push_value   (push_value),
        .empty        (empty),
        .pop          (pop),
        .pop_value    (pop_value),
        .status       (status),
        .occupancy    (occupancy),
        .mismatches   (mismatches),
        .pending      (pending),
        .requests_seen(requests_seen),
        .results_seen (results_seen),
        .refused_full (refused_full),
        .refused_empty(refused_empty)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: pop at random, except for one long hold-off at the start of
    // the steady mix, so the block backs up and raises full on the request side.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (steady_mix && !hold_done)
        begin
            pop       <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
        begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no request or result accepted for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request; called and returns at a falling edge. Idle cycles
    // drop push first; push stays high across back-to-back requests.
    task automatic send_request(input logic [1:0] op, input logic [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        opcode     <= op;
        push_value <= val;
        // Hold the request until an edge sees full low.
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Favor the corner words, otherwise a fully random one.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Lean toward pushes or pops so runs reach both full and empty.
    function automatic logic [1:0] pick_opcode(input lean_t lean);
        int   roll;
        logic do_push;
        roll = $urandom_range(0, 99);
        case (lean)
            LEAN_FILL:  do_push = (roll < 85);
            LEAN_DRAIN: do_push = (roll < 15);
            default:    do_push = (roll < 50);
        endcase
        if (do_push)
            return $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
    endfunction

    // Random requests in runs of 16 with a fresh lean per run.
    task automatic run_random(input int count);
        lean_t lean;
        lean = LEAN_EVEN;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                lean = lean_t'($urandom_range(0, 2));
            send_request(pick_opcode(lean), pick_value());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pops on an empty deque; the offered value must be ignored.
        send_request(cdq_pkg::OP_POP_FRONT, 32'h1234_5678);
        send_request(cdq_pkg::OP_POP_REAR, 32'hFFFF_FFFF);
        // Single element pushed at one end and popped from the other.
        send_request(cdq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(cdq_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_request(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_request(cdq_pkg::OP_POP_REAR, 32'h0000_0000);
        // Fill to full from both ends with walking ones and zeros.
        for (int i = 0; i < DEPTH; i++)
        begin
            send_request(i[0] ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT,
                         i[0] ? ~(32'h1 << (2 * i)) : (32'h1 << (2 * i + 1)));
        end
        // Pushes on a full deque are refused.
        send_request(cdq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(cdq_pkg::OP_PUSH_REAR, 32'h5555_5555);

        run_random(ITEMS_PER_MIX);

        send_idle_pct <= 75;
        recv_idle_pct <= 18;
        run_random(ITEMS_PER_MIX);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        steady_mix    <= 1'b1;
        run_random(ITEMS_PER_MIX);
        push <= 1'b0;

        // Wait for every owed result, then watch a while for strays.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d refused as full, %0d refused as empty),",
                 requests_seen, refused_full, refused_empty);
        $display("%0d results checked; idling mixes: sender-light, receiver-light, none.",
                 results_seen);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
